// File: hdl/jsu_pkg.sv
// shared types, codes and helpers for the json string unescape and validate block
// no dependencies; used by every file of the block except the two channel interfaces
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // result status codes
  localparam logic [3:0] ST_DATA         = 4'd0;
  localparam logic [3:0] ST_CLOSED       = 4'd1;
  localparam logic [3:0] ST_NO_QUOTE     = 4'd2;
  localparam logic [3:0] ST_UNTERMINATED = 4'd3;
  localparam logic [3:0] ST_ESC_CUT      = 4'd4;
  localparam logic [3:0] ST_BAD_ESCAPE   = 4'd5;
  localparam logic [3:0] ST_BAD_HEX      = 4'd6;
  localparam logic [3:0] ST_NO_LOW       = 4'd7;
  localparam logic [3:0] ST_BAD_LOW      = 4'd8;
  localparam logic [3:0] ST_LONE_LOW     = 4'd9;
  localparam logic [3:0] ST_CTRL_CHAR    = 4'd10;
  localparam logic [3:0] ST_BAD_UTF8     = 4'd11;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_U      = 8'h75;

  // all results caused by one item
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic [3:0]      status;
  } run_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic run_t encode_cp(input logic [20:0] cp);
    run_t r;
    r.bytes  = '0;
    r.status = ST_DATA;
    if (cp <= 21'h7f) begin
      r.count    = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      r.count    = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.count    = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// File: hdl/jsu_in_if.sv
// input channel: one text byte or an end-of-text mark per item
// no dependencies
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_ended;

  modport source(output valid, output in_byte, output text_ended, input ready);
  modport sink(input valid, input in_byte, input text_ended, output ready);
endinterface

// File: hdl/jsu_out_if.sv
// output channel: one decoded byte or status per item
// no dependencies
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last_of_run;

  modport source(output valid, output out_byte, output status, output last_of_run,
                 input ready);
  modport sink(input valid, input out_byte, input status, input last_of_run,
               output ready);
endinterface

// File: hdl/json_string_unescape_validate.sv
// JSON string decoder: takes the text of one string a byte per item from the opening quote,
// returns decoded UTF-8 bytes, a closed status or an error status, with last_of_run on the
// final result of each input item. An input item is taken every cycle while the four-deep
// run queue has space; each item gives zero to four results and the output side delivers
// one result per cycle while the receiver is ready, so the sustained rate is one item per
// cycle for text that gives at most one result per byte and is set by the result rate
// otherwise. A result passes through its queue entry and then the output register.
module json_string_unescape_validate (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);

  logic          push;
  logic          push_ready;
  jsu_pkg::run_t push_data;
  logic          pop_valid;
  logic          pop;
  jsu_pkg::run_t pop_data;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push       (push),
    .run        (push_data),
    .push_ready (push_ready)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: hdl/jsu_front.sv
// front end: accepts text bytes, runs the string / escape / utf-8 state machine
// and builds one run of results per item; uses jsu_pkg and jsu_in_if
module jsu_front (
  input  logic           clk,
  input  logic           rst,
  jsu_in_if.sink         text,
  output logic           push,
  output jsu_pkg::run_t  run,
  input  logic           push_ready
);

  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_STR       = 3'd1;
  localparam logic [2:0] M_ESC       = 3'd2;
  localparam logic [2:0] M_HEX_FIRST = 3'd3;
  localparam logic [2:0] M_SUR_BS    = 3'd4;
  localparam logic [2:0] M_SUR_U     = 3'd5;
  localparam logic [2:0] M_HEX_LOW   = 3'd6;
  localparam logic [2:0] M_UTF8      = 3'd7;

  logic [2:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  high_half, high_half_next;
  logic [7:0]  seq_bytes [3];
  logic [2:0]  seq_need, seq_need_next;
  logic [1:0]  seq_have, seq_have_next;
  logic        seq_wr;
  logic [1:0]  seq_wr_idx;

  logic        accept;
  logic [7:0]  b;
  logic        ended;
  logic [4:0]  hd;
  logic [15:0] v;
  logic [10:0] plane;

  assign text.ready = push_ready;
  assign accept     = text.valid && text.ready;
  assign push       = accept && (run.count != 3'd0);
  assign b          = text.in_byte;
  assign ended      = text.text_ended;
  assign hd         = jsu_pkg::hex_nibble(b);
  assign v          = {hex_accum[11:0], hd[3:0]};
  // supplementary code point is ((high + 0x40) << 10) | low
  assign plane      = {1'b0, high_half} + 11'd64;

  always_comb begin
    mode_next      = mode;
    hex_count_next = hex_count;
    hex_accum_next = hex_accum;
    high_half_next = high_half;
    seq_need_next  = seq_need;
    seq_have_next  = seq_have;
    seq_wr         = 1'b0;
    seq_wr_idx     = seq_have;
    run.bytes      = '0;
    run.count      = 3'd0;
    run.status     = jsu_pkg::ST_DATA;

    unique case (mode)
      M_IDLE: begin
        if (ended || b != jsu_pkg::CH_QUOTE) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_NO_QUOTE;
        end else begin
          mode_next = M_STR;
        end
      end
      M_STR: begin
        if (ended) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_UNTERMINATED;
          mode_next  = M_IDLE;
        end else if (b == jsu_pkg::CH_QUOTE) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_CLOSED;
          mode_next  = M_IDLE;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          mode_next = M_ESC;
        end else if (b < 8'h20) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_CTRL_CHAR;
          mode_next  = M_IDLE;
        end else if (b < 8'h80) begin
          run.count    = 3'd1;
          run.bytes[0] = b;
        end else if (b >= 8'hc2 && b <= 8'hf4) begin
          if (b <= 8'hdf) begin
            seq_need_next = 3'd2;
          end else if (b <= 8'hef) begin
            seq_need_next = 3'd3;
          end else begin
            seq_need_next = 3'd4;
          end
          seq_wr        = 1'b1;
          seq_wr_idx    = 2'd0;
          seq_have_next = 2'd1;
          mode_next     = M_UTF8;
        end else begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_BAD_UTF8;
          mode_next  = M_IDLE;
        end
      end
      M_ESC: begin
        mode_next = M_STR;
        run.count = 3'd1;
        if (ended) begin
          run.status = jsu_pkg::ST_ESC_CUT;
          mode_next  = M_IDLE;
        end else begin
          unique case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: run.bytes[0] = b;
            8'h62:   run.bytes[0] = 8'h08;
            8'h66:   run.bytes[0] = 8'h0c;
            8'h6e:   run.bytes[0] = 8'h0a;
            8'h72:   run.bytes[0] = 8'h0d;
            8'h74:   run.bytes[0] = 8'h09;
            jsu_pkg::CH_U: begin
              run.count      = 3'd0;
              mode_next      = M_HEX_FIRST;
              hex_count_next = 2'd0;
              hex_accum_next = 16'd0;
            end
            default: begin
              run.status = jsu_pkg::ST_BAD_ESCAPE;
              mode_next  = M_IDLE;
            end
          endcase
        end
      end
      M_HEX_FIRST, M_HEX_LOW: begin
        if (ended) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_ESC_CUT;
          mode_next  = M_IDLE;
        end else if (!hd[4]) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_BAD_HEX;
          mode_next  = M_IDLE;
        end else begin
          hex_accum_next = v;
          if (hex_count != 2'd3) begin
            hex_count_next = hex_count + 2'd1;
          end else if (mode == M_HEX_FIRST) begin
            if (v[15:10] == 6'b110110) begin
              high_half_next = v[9:0];
              mode_next      = M_SUR_BS;
            end else if (v[15:10] == 6'b110111) begin
              run.count  = 3'd1;
              run.status = jsu_pkg::ST_LONE_LOW;
              mode_next  = M_IDLE;
            end else begin
              run       = jsu_pkg::encode_cp({5'd0, v});
              mode_next = M_STR;
            end
          end else begin
            if (v[15:10] != 6'b110111) begin
              run.count  = 3'd1;
              run.status = jsu_pkg::ST_BAD_LOW;
              mode_next  = M_IDLE;
            end else begin
              run       = jsu_pkg::encode_cp({plane, v[9:0]});
              mode_next = M_STR;
            end
          end
        end
      end
      M_SUR_BS: begin
        if (ended || b != jsu_pkg::CH_BSLASH) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_NO_LOW;
          mode_next  = M_IDLE;
        end else begin
          mode_next = M_SUR_U;
        end
      end
      M_SUR_U: begin
        if (ended || b != jsu_pkg::CH_U) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_NO_LOW;
          mode_next  = M_IDLE;
        end else begin
          mode_next      = M_HEX_LOW;
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end
      end
      M_UTF8: begin
        if (ended || b[7:6] != 2'b10 ||
            (seq_have == 2'd1 &&
             ((seq_bytes[0] == 8'he0 && b < 8'ha0) ||
              (seq_bytes[0] == 8'hed && b > 8'h9f) ||
              (seq_bytes[0] == 8'hf0 && b < 8'h90) ||
              (seq_bytes[0] == 8'hf4 && b > 8'h8f)))) begin
          run.count  = 3'd1;
          run.status = jsu_pkg::ST_BAD_UTF8;
          mode_next  = M_IDLE;
        end else if ({1'b0, seq_have} + 3'd1 >= seq_need || seq_have == 2'd3) begin
          // sequence complete: pass the held bytes and this one on
          run.count    = {1'b0, seq_have} + 3'd1;
          run.bytes[0] = seq_bytes[0];
          run.bytes[1] = (seq_have == 2'd1) ? b : seq_bytes[1];
          run.bytes[2] = (seq_have == 2'd2) ? b : ((seq_have == 2'd3) ? seq_bytes[2] : 8'd0);
          run.bytes[3] = (seq_have == 2'd3) ? b : 8'd0;
          mode_next    = M_STR;
        end else begin
          seq_wr        = 1'b1;
          seq_have_next = seq_have + 2'd1;
        end
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_count <= 2'd0;
      hex_accum <= 16'd0;
      high_half <= 10'd0;
      seq_need  <= 3'd0;
      seq_have  <= 2'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      hex_accum <= hex_accum_next;
      high_half <= high_half_next;
      seq_need  <= seq_need_next;
      seq_have  <= seq_have_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && seq_wr && seq_wr_idx != 2'd3) begin
      seq_bytes[seq_wr_idx] <= b;
    end
  end

`ifndef ASSERT_OFF
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (run.count != 3'd0 && run.count <= 3'd4))
    else $error("front pushed an empty or oversized run");
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (push && run.status != jsu_pkg::ST_DATA) |-> (run.count == 3'd1 && mode_next == M_IDLE))
    else $error("status run not single or not back to idle");
  a_utf8_have: assert property (@(posedge clk) disable iff (rst)
    (mode == M_UTF8) |-> (seq_have != 2'd0 && {1'b0, seq_have} < seq_need))
    else $error("utf-8 sequence count out of range");
`endif

endmodule

// File: hdl/jsu_queue.sv
// short run queue between the front end and the result serialiser
// uses jsu_pkg
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::run_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output jsu_pkg::run_t pop_data,
  input  logic          pop
);

  jsu_pkg::run_t                   mem [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0]      fill;
  logic                            do_push, do_pop;

  assign push_ready = (fill != jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill != jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH)) |->
      (jsu_pkg::QPTR_W'(fill) == jsu_pkg::QPTR_W'(wr_ptr - rd_ptr)))
    else $error("queue fill count disagrees with pointers");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH))
    else $error("queue fill above depth");
  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("run pushed into a full queue");
`endif

endmodule

// File: hdl/jsu_back.sv
// result serialiser: walks each queued run and drives one result item per cycle while the
// receiver is ready, through an output register; uses jsu_pkg and jsu_out_if
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  jsu_pkg::run_t pop_data,
  output logic          pop,
  jsu_out_if.source     result
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic [3:0] out_status;
  logic       out_last;
  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = !out_valid || result.ready;
  assign is_last = ({1'b0, idx} == pop_data.count - 3'd1);
  assign pop     = load && pop_valid && is_last;

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.status      = out_status;
  assign result.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      out_byte   <= pop_data.bytes[idx];
      out_status <= pop_data.status;
      out_last   <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0))
    else $error("run index not restarted after a run");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != jsu_pkg::ST_DATA) |-> (out_last && out_byte == 8'd0))
    else $error("status result not a single zero-byte result");
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> ({1'b0, idx} < pop_data.count))
    else $error("run index beyond run length");
`endif

endmodule

// File: dv/json_string_unescape_validate_test.sv
// testbench for json_string_unescape_validate: random and directed JSON string text,
// results checked against a scoreboard that decodes the same bytes
// depends on jsu_pkg, jsu_in_if, jsu_out_if and the block itself

typedef struct packed {
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last_of_run;
} decoded_t;

typedef enum logic [3:0] {
  PM_IDLE,
  PM_STR,
  PM_ESC,
  PM_HEX_FIRST,
  PM_SUR_BS,
  PM_SUR_U,
  PM_HEX_LOW,
  PM_UTF8
} parse_mode_t;

class decode_scoreboard;
  decoded_t    expected_q[$];
  decoded_t    run_q[$];
  int          mismatches;
  int          results_seen;
  parse_mode_t mode;
  logic [1:0]  hex_count;
  logic [15:0] hex_accum;
  logic [9:0]  high_half;
  logic [7:0]  seq_bytes[3];
  logic [2:0]  seq_need;
  logic [2:0]  seq_have;

  function new();
    mode         = PM_IDLE;
    hex_count    = '0;
    hex_accum    = '0;
    high_half    = '0;
    seq_need     = '0;
    seq_have     = '0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  function void emit(logic [7:0] b, logic [3:0] st);
    run_q.push_back('{b, st, 1'b0});
  endfunction

  function void fail_with(logic [3:0] st);
    mode = PM_IDLE;
    emit(8'h00, st);
  endfunction

  function int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function void emit_code_point(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      emit(cp[7:0], jsu_pkg::ST_DATA);
    end else if (cp <= 21'h7ff) begin
      emit({3'b110, cp[10:6]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_DATA);
    end else if (cp <= 21'hffff) begin
      emit({4'b1110, cp[15:12]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[11:6]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_DATA);
    end else begin
      emit({5'b11110, cp[20:18]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[17:12]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[11:6]}, jsu_pkg::ST_DATA);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_DATA);
    end
  endfunction

  function void string_byte(logic [7:0] b);
    if (b == jsu_pkg::CH_QUOTE) begin
      mode = PM_IDLE;
      emit(8'h00, jsu_pkg::ST_CLOSED);
    end else if (b == jsu_pkg::CH_BSLASH) begin
      mode = PM_ESC;
    end else if (b < 8'h20) begin
      fail_with(jsu_pkg::ST_CTRL_CHAR);
    end else if (b < 8'h80) begin
      emit(b, jsu_pkg::ST_DATA);
    end else if (b < 8'hc2 || b > 8'hf4) begin
      fail_with(jsu_pkg::ST_BAD_UTF8);
    end else begin
      if (b <= 8'hdf) seq_need = 3'd2;
      else if (b <= 8'hef) seq_need = 3'd3;
      else seq_need = 3'd4;
      seq_bytes[0] = b;
      seq_have     = 3'd1;
      mode         = PM_UTF8;
    end
  endfunction

  function void utf8_byte(logic [7:0] b);
    logic [7:0] lead;
    lead = seq_bytes[0];
    if (b < 8'h80 || b > 8'hbf) begin
      fail_with(jsu_pkg::ST_BAD_UTF8);
      return;
    end
    // second byte range depends on the lead for overlongs, surrogates and the top limit
    if (seq_have == 3'd1 && ((lead == 8'he0 && b < 8'ha0) || (lead == 8'hed && b > 8'h9f) ||
                             (lead == 8'hf0 && b < 8'h90) || (lead == 8'hf4 && b > 8'h8f))) begin
      fail_with(jsu_pkg::ST_BAD_UTF8);
      return;
    end
    if (int'(seq_have) + 1 >= int'(seq_need) || seq_have >= 3'd3) begin
      for (int i = 0; i < int'(seq_have) && i < 3; i++) emit(seq_bytes[i], jsu_pkg::ST_DATA);
      emit(b, jsu_pkg::ST_DATA);
      mode = PM_STR;
    end else begin
      seq_bytes[seq_have[1:0]] = b;
      seq_have = seq_have + 3'd1;
    end
  endfunction

  function void hex_byte(logic [7:0] b);
    int          d;
    logic [15:0] v;
    d = hex_value(b);
    if (d < 0) begin
      fail_with(jsu_pkg::ST_BAD_HEX);
      return;
    end
    hex_accum = {hex_accum[11:0], d[3:0]};
    if (hex_count < 2'd3) begin
      hex_count = hex_count + 2'd1;
      return;
    end
    v = hex_accum;
    if (mode == PM_HEX_FIRST) begin
      if (v >= 16'hd800 && v <= 16'hdbff) begin
        high_half = v[9:0];
        mode      = PM_SUR_BS;
      end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
        fail_with(jsu_pkg::ST_LONE_LOW);
      end else begin
        mode = PM_STR;
        emit_code_point({5'd0, v});
      end
    end else if (v < 16'hdc00 || v > 16'hdfff) begin
      fail_with(jsu_pkg::ST_BAD_LOW);
    end else begin
      mode = PM_STR;
      emit_code_point(21'h10000 + {1'b0, high_half, 10'd0} + {5'd0, v - 16'hdc00});
    end
  endfunction

  function void escape_byte(logic [7:0] b);
    logic [7:0] d;
    case (b)
      jsu_pkg::CH_QUOTE:  d = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSLASH: d = jsu_pkg::CH_BSLASH;
      jsu_pkg::CH_SLASH:  d = jsu_pkg::CH_SLASH;
      "b":                d = 8'h08;
      "f":                d = 8'h0c;
      "n":                d = 8'h0a;
      "r":                d = 8'h0d;
      "t":                d = 8'h09;
      jsu_pkg::CH_U: begin
        mode      = PM_HEX_FIRST;
        hex_count = '0;
        hex_accum = '0;
        return;
      end
      default: begin
        fail_with(jsu_pkg::ST_BAD_ESCAPE);
        return;
      end
    endcase
    mode = PM_STR;
    emit(d, jsu_pkg::ST_DATA);
  endfunction

  // decode one accepted input item and queue the results it should cause
  function void note_item(logic [7:0] b, logic ended);
    decoded_t r;
    case (mode)
      PM_STR: begin
        if (ended) fail_with(jsu_pkg::ST_UNTERMINATED);
        else string_byte(b);
      end
      PM_ESC: begin
        if (ended) fail_with(jsu_pkg::ST_ESC_CUT);
        else escape_byte(b);
      end
      PM_HEX_FIRST, PM_HEX_LOW: begin
        if (ended) fail_with(jsu_pkg::ST_ESC_CUT);
        else hex_byte(b);
      end
      PM_SUR_BS: begin
        if (ended || b != jsu_pkg::CH_BSLASH) fail_with(jsu_pkg::ST_NO_LOW);
        else mode = PM_SUR_U;
      end
      PM_SUR_U: begin
        if (ended || b != jsu_pkg::CH_U) begin
          fail_with(jsu_pkg::ST_NO_LOW);
        end else begin
          mode      = PM_HEX_LOW;
          hex_count = '0;
          hex_accum = '0;
        end
      end
      PM_UTF8: begin
        if (ended) fail_with(jsu_pkg::ST_BAD_UTF8);
        else utf8_byte(b);
      end
      default: begin
        mode = PM_IDLE;
        if (ended || b != jsu_pkg::CH_QUOTE) fail_with(jsu_pkg::ST_NO_QUOTE);
        else mode = PM_STR;
      end
    endcase
    for (int i = 0; i < run_q.size(); i++) begin
      r = run_q[i];
      r.last_of_run = (i == run_q.size() - 1);
      expected_q.push_back(r);
    end
    run_q.delete();
  endfunction

  function void check_result(logic [7:0] b, logic [3:0] st, logic last);
    decoded_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: none expected, got byte %h status %0d last %b",
                 results_seen, b, st, last);
      return;
    end
    e = expected_q.pop_front();
    if (b !== e.out_byte || st !== e.status || last !== e.last_of_run) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                 results_seen, e.out_byte, e.status, e.last_of_run, b, st, last);
    end
  endfunction

  function void flag_leftovers();
    if (expected_q.size() != 0) begin
      mismatches += expected_q.size();
      $display("%0d expected results never arrived", expected_q.size());
    end
  endfunction
endclass

module json_string_unescape_validate_test;
  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  text_ch();
  jsu_out_if result_ch();

  json_string_unescape_validate dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  decode_scoreboard sb = new();

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_requests  = 0;
  int         items_sent     = 0;
  int         quiet_cycles   = 0;
  logic [7:0] token_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int held;
    int seen;
    held = 0;
    seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready)
      sb.note_item(text_ch.in_byte, text_ch.text_ended);
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.out_byte, result_ch.status, result_ch.last_of_run);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("json_string_unescape_validate verification failed");
        $finish;
      end
    end
  end

  task automatic drive_item(input logic [7:0] b, input logic ended);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.in_byte    <= b;
    text_ch.text_ended <= ended;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drive_text_end();
    drive_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void add_u_escape(input logic [15:0] v);
    token_q.push_back(jsu_pkg::CH_BSLASH);
    token_q.push_back(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) token_q.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] pick_bmp_value();
    logic [15:0] edges[8];
    logic [15:0] v;
    edges = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hd7ff, 16'he000, 16'hffff};
    if ($urandom_range(3) == 0) return edges[$urandom_range(7)];
    case ($urandom_range(2))
      0: v = 16'($urandom_range(16'h7f));
      1: v = 16'($urandom_range(16'h7ff, 16'h80));
      default: begin
        do v = 16'($urandom_range(16'hffff, 16'h800));
        while (v >= 16'hd800 && v <= 16'hdfff);
      end
    endcase
    return v;
  endfunction

  function automatic void add_raw_utf8();
    logic [7:0] lead;
    logic [7:0] leads3[4];
    leads3 = '{8'he0, 8'hed, 8'hef, 8'he1};
    case ($urandom_range(2))
      0: begin
        token_q.push_back(8'($urandom_range(8'hdf, 8'hc2)));
        token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
      end
      1: begin
        if ($urandom_range(2) == 0) lead = leads3[$urandom_range(3)];
        else lead = 8'($urandom_range(8'hef, 8'he0));
        token_q.push_back(lead);
        if (lead == 8'he0) token_q.push_back(8'($urandom_range(8'hbf, 8'ha0)));
        else if (lead == 8'hed) token_q.push_back(8'($urandom_range(8'h9f, 8'h80)));
        else token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
        token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
      end
      default: begin
        lead = 8'($urandom_range(8'hf4, 8'hf0));
        token_q.push_back(lead);
        if (lead == 8'hf0) token_q.push_back(8'($urandom_range(8'hbf, 8'h90)));
        else if (lead == 8'hf4) token_q.push_back(8'($urandom_range(8'h8f, 8'h80)));
        else token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
        token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
        token_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
      end
    endcase
  endfunction

  // one piece of string content, occasionally damaged or cut short by the end of text
  task automatic send_token();
    logic [7:0]  simple_escapes[8];
    logic [7:0]  b;
    logic [15:0] low;
    int          kind;
    int          cut;
    simple_escapes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                       "b", "f", "n", "r", "t"};
    token_q.delete();
    kind = $urandom_range(99);
    if (kind < 30) begin
      do b = 8'($urandom_range(8'h7f, 8'h20));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      token_q.push_back(b);
    end else if (kind < 45) begin
      token_q.push_back(jsu_pkg::CH_BSLASH);
      token_q.push_back(simple_escapes[$urandom_range(7)]);
    end else if (kind < 60) begin
      add_u_escape(pick_bmp_value());
    end else if (kind < 72) begin
      add_u_escape(16'($urandom_range(16'hdbff, 16'hd800)));
      if ($urandom_range(9) == 0) low = 16'($urandom_range(16'hffff));
      else low = 16'($urandom_range(16'hdfff, 16'hdc00));
      add_u_escape(low);
    end else if (kind < 76) begin
      add_u_escape(16'($urandom_range(16'hffff)));
    end else if (kind < 97) begin
      add_raw_utf8();
    end else begin
      token_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 8)
      token_q[$urandom_range(token_q.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 4) begin
      cut = $urandom_range(token_q.size() - 1);
      for (int i = 0; i < cut; i++) drive_item(token_q[i], 1'b0);
      drive_text_end();
    end else begin
      foreach (token_q[i]) drive_item(token_q[i], 1'b0);
    end
  endtask

  task automatic send_string();
    int ending;
    if ($urandom_range(99) < 5) drive_item(8'($urandom_range(255)), 1'b0);
    drive_item(jsu_pkg::CH_QUOTE, 1'b0);
    repeat ($urandom_range(6)) send_token();
    ending = $urandom_range(99);
    if (ending < 85) drive_item(jsu_pkg::CH_QUOTE, 1'b0);
    else if (ending < 93) drive_text_end();
    else drive_item(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_directed();
    logic [7:0] seq[$];
    // text outside a string, as a byte and as an end of text
    drive_item(8'h00, 1'b0);
    drive_item(8'hff, 1'b1);
    // top code point from a surrogate pair in mixed case, then an escaped zero
    seq = '{jsu_pkg::CH_QUOTE,
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "D", "b", "F", "f",
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "d", "F", "F", "F",
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "0", "0", "0", "0",
            jsu_pkg::CH_QUOTE};
    foreach (seq[i]) drive_item(seq[i], 1'b0);
    // invalid lead byte, then a string cut short
    drive_item(jsu_pkg::CH_QUOTE, 1'b0);
    drive_item(8'hff, 1'b0);
    drive_item(jsu_pkg::CH_QUOTE, 1'b0);
    drive_text_end();
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int target;
    idle_by_phase  = '{0, 80, 0, 38};
    stall_by_phase = '{0, 0, 80, 38};
    rst                = 1'b1;
    text_ch.valid      = 1'b0;
    text_ch.in_byte    = 8'h00;
    text_ch.text_ended = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_directed();
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      // long receiver hold-off while text keeps coming, so the block backs up
      if (phase == 0 || phase == 3) hold_requests++;
      target += RANDOM_ITEMS / 4;
      while (items_sent < target) send_string();
    end
    text_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("json_string_unescape_validate verification clean");
    end else begin
      $display("json_string_unescape_validate verification failed");
    end
    $finish;
  end
endmodule
